// File: src/bpemt_pkg.sv
// Package for the BPE merge trainer: sizes, field widths, status codes,
// register indexes and the sequencer state type. No dependencies.
`default_nettype none
package bpemt_pkg;
    localparam int CORPUS_DEPTH     = 65536;
    localparam int WORD_DEPTH       = 16384;
    localparam int PAIR_TABLE_DEPTH = 4096;
    localparam int SYMBOL_BITS      = 16;

    localparam int CA_W  = $clog2(CORPUS_DEPTH);
    localparam int CL_W  = $clog2(CORPUS_DEPTH + 1);
    localparam int WA_W  = $clog2(WORD_DEPTH);
    localparam int WL_W  = $clog2(WORD_DEPTH + 1);
    localparam int PA_W  = $clog2(PAIR_TABLE_DEPTH);
    localparam int PL_W  = $clog2(PAIR_TABLE_DEPTH + 1);
    localparam int KEY_W = 2 * SYMBOL_BITS;
    localparam int CNT_W = 48;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_MERGED   = 2'd0,
        ST_NO_PAIR  = 2'd1,
        ST_VOCAB    = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_VOCAB_LIMIT = 2'd0,
        REG_MIN_COUNT   = 2'd1,
        REG_FIRST_ID    = 2'd2,
        REG_NONE        = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_T_RD,
        S_T_GOT,
        S_T_FREQ,
        S_T_SRCH,
        S_T_CMP,
        S_S_RD,
        S_S_CMP,
        S_A_RD,
        S_A_GOT,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

// File: src/bpe_merge_trainer.sv
// BPE merge trainer top level: corpus, word frequency and pair table memories
// under one sequencer with a shared compare/add unit. Uses bpemt_pkg.
//
// channel   direction  handshake                      payload
// command   in         start && !busy                 i_action, i_symbol_id, i_word_freq, i_word_end
// result    out        o_valid (one cycle, no stall)  o_status, o_left_id, o_right_id, o_merged_id,
//                                                     o_pair_count, o_symbol_count
// config    in/out     psel & penable & pwrite        paddr, pwdata, prdata, pready
//
// A load item is taken in the idle state and does not raise busy. A merge item runs
// a counting pass over the corpus, a selection pass over the pair table and, if a pair
// qualifies, an apply pass over the corpus; the table is searched one entry at a time
// through its single read port. Without a qualifying pair the apply pass is skipped.
// Status 2 and 3 at acceptance: no pass runs, and the result shows while busy is high.
// Reset is synchronous; memories are not cleared. The receiver cannot stall the result.
`default_nettype none
module bpe_merge_trainer
    import bpemt_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic                    i_action,
    input  wire logic [SYMBOL_BITS-1:0]  i_symbol_id,
    input  wire logic [31:0]             i_word_freq,
    input  wire logic                    i_word_end,
    output logic                         o_valid,
    output logic [1:0]                   o_status,
    output logic [15:0]                  o_left_id,
    output logic [15:0]                  o_right_id,
    output logic [15:0]                  o_merged_id,
    output logic [47:0]                  o_pair_count,
    output logic [15:0]                  o_symbol_count,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [3:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    // memories
    logic [SYMBOL_BITS:0]     corpus_mem [CORPUS_DEPTH];
    logic [31:0]              freq_mem   [WORD_DEPTH];
    logic [KEY_W+CNT_W-1:0]   pair_mem   [PAIR_TABLE_DEPTH];
    logic [SYMBOL_BITS:0]     r_crd;
    logic [31:0]              r_frd;
    logic [KEY_W+CNT_W-1:0]   r_prd;

    t_state r_state, n_state;
    logic [CL_W-1:0]        r_len, n_len, r_j, n_j, r_wr, n_wr;
    logic [WL_W-1:0]        r_wtot, n_wtot, r_w, n_w;
    logic                   r_ovf, n_ovf;
    logic [15:0]            r_vlim, r_fid, r_next, n_next, r_mid, n_mid;
    logic [31:0]            r_minc;
    logic                   r_pv, n_pv, r_pwe, n_pwe;
    logic [SYMBOL_BITS-1:0] r_psym, n_psym;
    logic [KEY_W-1:0]       r_key, n_key, r_bkey, n_bkey;
    logic [31:0]            r_freq, n_freq;
    logic [PL_W-1:0]        r_k, n_k, r_n, n_n;
    logic [CNT_W-1:0]       r_best, n_best;
    t_status                r_status, n_status;

    logic                   c_we, f_we, p_we;
    logic [CA_W-1:0]        c_waddr;
    logic [SYMBOL_BITS:0]   c_wdata;
    logic [PA_W-1:0]        p_waddr;
    logic [KEY_W+CNT_W-1:0] p_wdata;

    logic                   accept, cfg_wr;
    logic [SYMBOL_BITS-1:0] cur_sym;
    logic                   cur_we;
    logic [KEY_W-1:0]       ent_key;
    logic [CNT_W-1:0]       ent_cnt;
    logic [CNT_W:0]         sum;
    t_reg_idx               cfg_idx;

    assign accept  = start && !busy;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);
    assign cur_sym = r_crd[SYMBOL_BITS-1:0];
    assign cur_we  = r_crd[SYMBOL_BITS];
    assign ent_key = r_prd[KEY_W+CNT_W-1:CNT_W];
    assign ent_cnt = r_prd[CNT_W-1:0];
    // adder: pair count plus word frequency
    assign sum     = {1'b0, ent_cnt} + {{(CNT_W-31){1'b0}}, r_freq};

    always_ff @(posedge i_clk) begin
        r_crd <= corpus_mem[r_j[CA_W-1:0]];
        r_frd <= freq_mem[r_w[WA_W-1:0]];
        r_prd <= pair_mem[r_k[PA_W-1:0]];
        if (c_we) begin
            corpus_mem[c_waddr] <= c_wdata;
        end
        if (f_we) begin
            freq_mem[r_wtot[WA_W-1:0]] <= i_word_freq;
        end
        if (p_we) begin
            pair_mem[p_waddr] <= p_wdata;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_action) begin
                    n_state = (r_ovf || r_next >= r_vlim) ? S_DONE : S_T_RD;
                end
            end
            S_T_RD:   n_state = (r_j == r_len) ? S_S_RD : S_T_GOT;
            S_T_GOT:  n_state = (r_pv && !r_pwe) ? S_T_FREQ : S_T_RD;
            S_T_FREQ: n_state = S_T_SRCH;
            S_T_SRCH: begin
                if (r_k == r_n) begin
                    n_state = (r_n == PL_W'(PAIR_TABLE_DEPTH)) ? S_DONE : S_T_RD;
                end else begin
                    n_state = S_T_CMP;
                end
            end
            S_T_CMP:  n_state = (ent_key == r_key) ? S_T_RD : S_T_SRCH;
            S_S_RD: begin
                if (r_k == r_n) begin
                    n_state = (r_best == '0) ? S_DONE : S_A_RD;
                end else begin
                    n_state = S_S_CMP;
                end
            end
            S_S_CMP:  n_state = S_S_RD;
            S_A_RD:   n_state = (r_j == r_len) ? S_DONE : S_A_GOT;
            S_A_GOT:  n_state = S_A_RD;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_len = r_len;   n_j = r_j;       n_wr = r_wr;     n_wtot = r_wtot;
        n_w = r_w;       n_ovf = r_ovf;   n_next = r_next; n_mid = r_mid;
        n_pv = r_pv;     n_pwe = r_pwe;   n_psym = r_psym; n_key = r_key;
        n_bkey = r_bkey; n_freq = r_freq; n_k = r_k;       n_n = r_n;
        n_best = r_best; n_status = r_status;
        c_we = 1'b0; c_waddr = r_wr[CA_W-1:0]; c_wdata = {r_pwe, r_psym};
        f_we = 1'b0;
        p_we = 1'b0; p_waddr = r_k[PA_W-1:0]; p_wdata = {r_key, CNT_W'(r_freq)};

        unique case (r_state)
            S_IDLE: begin
                if (accept && !i_action) begin
                    if (r_len == CL_W'(CORPUS_DEPTH) || r_wtot == WL_W'(WORD_DEPTH)) begin
                        n_ovf = 1'b1;
                    end else begin
                        c_we    = 1'b1;
                        c_waddr = r_len[CA_W-1:0];
                        c_wdata = {i_word_end, i_symbol_id};
                        f_we    = 1'b1;
                        n_len   = r_len + 1'b1;
                        n_wtot  = r_wtot + WL_W'(i_word_end);
                    end
                end else if (accept) begin
                    n_best = '0; n_bkey = '0; n_mid = '0;
                    n_j = '0; n_w = '0; n_pv = 1'b0; n_pwe = 1'b0; n_n = '0; n_k = '0;
                    if (r_ovf) begin
                        n_status = ST_OVERFLOW;
                    end else if (r_next >= r_vlim) begin
                        n_status = ST_VOCAB;
                    end
                end
            end
            S_T_RD: begin
                n_k = '0;
            end
            S_T_GOT: begin
                n_key = {r_psym, cur_sym};
                if (!(r_pv && !r_pwe)) begin
                    n_w    = r_w + WL_W'(r_pv & r_pwe);
                    n_pv   = 1'b1;
                    n_psym = cur_sym;
                    n_pwe  = cur_we;
                    n_j    = r_j + 1'b1;
                end
            end
            S_T_FREQ: begin
                n_freq = r_frd;
            end
            S_T_SRCH: begin
                if (r_k == r_n) begin
                    if (r_n == PL_W'(PAIR_TABLE_DEPTH)) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        p_we   = 1'b1;
                        n_n    = r_n + 1'b1;
                        n_w    = r_w + WL_W'(r_pwe);
                        n_psym = cur_sym;
                        n_pwe  = cur_we;
                        n_j    = r_j + 1'b1;
                    end
                end
            end
            S_T_CMP: begin
                if (ent_key == r_key) begin
                    p_we    = 1'b1;
                    p_wdata = {r_key, sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0]};
                    n_w     = r_w + WL_W'(r_pwe);
                    n_psym  = cur_sym;
                    n_pwe   = cur_we;
                    n_j     = r_j + 1'b1;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_S_RD: begin
                if (r_k == r_n) begin
                    n_j = '0; n_wr = '0; n_pv = 1'b0;
                    if (r_best == '0) begin
                        n_status = ST_NO_PAIR;
                    end
                end
            end
            S_S_CMP: begin
                if (ent_cnt >= CNT_W'(r_minc) && ent_cnt > r_best) begin
                    n_best = ent_cnt;
                    n_bkey = ent_key;
                end
                n_k = r_k + 1'b1;
            end
            S_A_RD: begin
                if (r_j == r_len) begin
                    if (r_pv) begin
                        c_we = 1'b1;
                    end
                    n_len    = r_wr + CL_W'(r_pv);
                    n_mid    = r_next;
                    n_next   = r_next + 1'b1;
                    n_status = ST_MERGED;
                end
            end
            S_A_GOT: begin
                if (r_pv && !r_pwe && r_psym == r_bkey[KEY_W-1:SYMBOL_BITS]
                        && cur_sym == r_bkey[SYMBOL_BITS-1:0]) begin
                    c_we    = 1'b1;
                    c_wdata = {cur_we, r_next[SYMBOL_BITS-1:0]};
                    n_wr    = r_wr + 1'b1;
                    n_pv    = 1'b0;
                end else begin
                    c_we   = r_pv;
                    n_wr   = r_wr + CL_W'(r_pv);
                    n_pv   = 1'b1;
                    n_psym = cur_sym;
                    n_pwe  = cur_we;
                end
                n_j = r_j + 1'b1;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_wtot  <= '0;
            r_ovf   <= 1'b0;
            r_next  <= '0;
            r_vlim  <= 16'd1024;
            r_minc  <= '0;
            r_fid   <= '0;
            r_status <= ST_MERGED;
            r_pv    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_wtot   <= n_wtot;
            r_ovf    <= n_ovf;
            r_next   <= n_next;
            r_status <= n_status;
            r_pv     <= n_pv;
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_VOCAB_LIMIT: r_vlim <= pwdata[15:0];
                    REG_MIN_COUNT:   r_minc <= pwdata;
                    REG_FIRST_ID: begin
                        r_fid  <= pwdata[15:0];
                        r_next <= pwdata[15:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_j    <= n_j;
        r_wr   <= n_wr;
        r_w    <= n_w;
        r_mid  <= n_mid;
        r_pwe  <= n_pwe;
        r_psym <= n_psym;
        r_key  <= n_key;
        r_bkey <= n_bkey;
        r_freq <= n_freq;
        r_k    <= n_k;
        r_n    <= n_n;
        r_best <= n_best;
    end

    always_comb begin
        unique case (cfg_idx)
            REG_VOCAB_LIMIT: prdata = {16'd0, r_vlim};
            REG_MIN_COUNT:   prdata = r_minc;
            REG_FIRST_ID:    prdata = {16'd0, r_fid};
            default:         prdata = '0;
        endcase
    end

    assign pready         = 1'b1;
    assign busy           = (r_state != S_IDLE);
    assign o_valid        = (r_state == S_DONE);
    assign o_status       = r_status;
    assign o_left_id      = 16'(r_bkey[KEY_W-1:SYMBOL_BITS]);
    assign o_right_id     = 16'(r_bkey[SYMBOL_BITS-1:0]);
    assign o_merged_id    = r_mid;
    assign o_pair_count   = r_best;
    assign o_symbol_count = r_next;
endmodule
`default_nettype wire

// File: src/bpemt_checker.sv
// Port-level checker for the BPE merge trainer, bound to the top level.
// Uses bpemt_pkg for status codes.
`default_nettype none
module bpemt_checker
    import bpemt_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        i_action,
    input wire logic        o_valid,
    input wire logic [1:0]  o_status,
    input wire logic [15:0] o_left_id,
    input wire logic [15:0] o_merged_id,
    input wire logic [47:0] o_pair_count
);
    // a result comes only while a merge item is in flight
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result outside a merge");

    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_action) |=> !o_valid) else $error("load produced item");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_MERGED) |->
            (o_left_id == 16'd0 && o_merged_id == 16'd0 && o_pair_count == 48'd0))
        else $error("failed round shows pair data");

    a_merge_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_MERGED) |-> (o_pair_count != 48'd0))
        else $error("merged pair with zero count");
endmodule

bind bpe_merge_trainer bpemt_checker u_bpemt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .i_action(i_action), .o_valid(o_valid), .o_status(o_status),
    .o_left_id(o_left_id), .o_merged_id(o_merged_id), .o_pair_count(o_pair_count)
);
`default_nettype wire
